>>> hw/rtl/ctl_pkg.sv
package ctl_pkg;

    // token kinds as they appear on the result channel
    typedef enum logic [3:0] {
        K_IDENT   = 4'd0,
        K_LPAREN  = 4'd1,
        K_RPAREN  = 4'd2,
        K_LBRACE  = 4'd3,
        K_RBRACE  = 4'd4,
        K_INT     = 4'd5,
        K_FLOAT   = 4'd6,
        K_DOUBLE  = 4'd7,
        K_OP      = 4'd8,
        K_SEMI    = 4'd9,
        K_END_OK  = 4'd10,
        K_END_REJ = 4'd11
    } t_kind;

    // one result word
    typedef struct packed {
        t_kind       kind;
        logic [15:0] start_pos;
        logic [15:0] tok_len;
        logic        last;
    } t_result;

    // characters the scanner looks for
    localparam logic [7:0] C_NUL    = 8'h00;
    localparam logic [7:0] C_TAB    = 8'h09;
    localparam logic [7:0] C_CR     = 8'h0D;
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_LPAREN = 8'h28;
    localparam logic [7:0] C_RPAREN = 8'h29;
    localparam logic [7:0] C_STAR   = 8'h2A;
    localparam logic [7:0] C_PLUS   = 8'h2B;
    localparam logic [7:0] C_MINUS  = 8'h2D;
    localparam logic [7:0] C_DOT    = 8'h2E;
    localparam logic [7:0] C_SLASH  = 8'h2F;
    localparam logic [7:0] C_ZERO   = 8'h30;
    localparam logic [7:0] C_NINE   = 8'h39;
    localparam logic [7:0] C_SEMI   = 8'h3B;
    localparam logic [7:0] C_EQUAL  = 8'h3D;
    localparam logic [7:0] C_UP_A   = 8'h41;
    localparam logic [7:0] C_UP_F   = 8'h46;
    localparam logic [7:0] C_UP_Z   = 8'h5A;
    localparam logic [7:0] C_UNDER  = 8'h5F;
    localparam logic [7:0] C_LO_A   = 8'h61;
    localparam logic [7:0] C_LO_F   = 8'h66;
    localparam logic [7:0] C_LO_Z   = 8'h7A;
    localparam logic [7:0] C_LBRACE = 8'h7B;
    localparam logic [7:0] C_RBRACE = 8'h7D;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= C_LO_A && c <= C_LO_Z) || (c >= C_UP_A && c <= C_UP_Z);
    endfunction

    function automatic logic is_decimal(input logic [7:0] c);
        return c >= C_ZERO && c <= C_NINE;
    endfunction

    function automatic logic is_white(input logic [7:0] c);
        return c == C_SPACE || (c >= C_TAB && c <= C_CR);
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return c == C_PLUS || c == C_MINUS || c == C_SLASH || c == C_STAR || c == C_EQUAL;
    endfunction

endpackage

>>> hw/rtl/ctl_byte_if.sv
interface ctl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink (input valid, input ch, output ready);
endinterface

>>> hw/rtl/ctl_tok_if.sv
interface ctl_tok_if;
    import ctl_pkg::*;

    logic        valid;
    logic        ready;
    t_kind       kind;
    logic [15:0] start_pos;
    logic [15:0] tok_len;
    logic        last;

    modport source (output valid, output kind, output start_pos, output tok_len, output last,
                    input ready);
    modport sink (input valid, input kind, input start_pos, input tok_len, input last,
                  output ready);
endinterface

>>> hw/rtl/c_token_lexer_unit.sv
// Streaming lexer for a small C-like language: one text byte per word in, token words out
// (kind, start offset, length, last flag); byte 0 ends the text and yields an end word.
// The scanner state advances as each byte is taken, so one byte is accepted every clock while the input is ready.
// A byte yields zero, one or two result words; they go into a four-word result queue and
// the input is ready while the queue holds at most two words. Each word is written into the
// queue as its byte is taken. Every word stands for a token or end marker built from
// its own bytes, so words never run ahead of bytes by more than one pending token, and
// with a sink that takes a word every cycle the input never stalls. Offsets and lengths
// saturate at 2^POS_BITS-1 and are reported clamped to 16 bits.
module c_token_lexer_unit #(
    parameter int POS_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ctl_byte_if.sink  i_in,
    ctl_tok_if.source o_out
);
    import ctl_pkg::*;

    typedef enum logic [2:0] {
        M_START  = 3'd0,
        M_IDENT  = 3'd1,
        M_ZERO   = 3'd2,
        M_INT    = 3'd3,
        M_FRAC   = 3'd4,
        M_REJECT = 3'd5
    } t_mode;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef logic [POS_BITS-1:0] t_pos;

    function automatic t_pos sat_inc(input t_pos v);
        return (v == '1) ? v : v + t_pos'(1);
    endfunction

    function automatic logic [15:0] clamp16(input t_pos v);
        logic [31:0] ext;
        ext = 32'(v);
        return (ext > 32'h0000_FFFF) ? 16'hFFFF : ext[15:0];
    endfunction

    function automatic t_result make_res(input t_kind k, input t_pos s, input t_pos l);
        t_result r;
        r.kind      = k;
        r.start_pos = clamp16(s);
        r.tok_len   = clamp16(l);
        r.last      = 1'b0;
        return r;
    endfunction

    t_mode   r_mode, n_mode;
    t_pos    r_pos, n_pos;
    t_pos    r_tstart, n_tstart;
    t_pos    r_tlen, n_tlen;

    t_result r_q [QDEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QAW:0]   r_cnt;

    t_result    res [2];
    logic [1:0] nres;

    logic [7:0] c;
    logic       acc, pop;

    assign c   = i_in.ch;
    assign acc = i_in.valid && i_in.ready;
    assign pop = o_out.valid && o_out.ready;

    assign i_in.ready      = r_cnt <= (QAW+1)'(QDEPTH - 2);
    assign o_out.valid     = r_cnt != '0;
    assign o_out.kind      = r_q[r_rd].kind;
    assign o_out.start_pos = r_q[r_rd].start_pos;
    assign o_out.tok_len   = r_q[r_rd].tok_len;
    assign o_out.last      = r_q[r_rd].last;

    // scanner step for the byte on the input
    always_comb begin
        logic done;
        logic ended;
        done     = 1'b0;
        ended    = 1'b0;
        nres     = 2'd0;
        res[0]   = make_res(K_END_OK, r_pos, '0);
        res[1]   = make_res(K_END_OK, r_pos, '0);
        n_mode   = r_mode;
        n_pos    = sat_inc(r_pos);
        n_tstart = r_tstart;
        n_tlen   = r_tlen;

        if (r_mode == M_REJECT) begin
            done = 1'b1;
            if (c == C_NUL) begin
                res[0] = make_res(K_END_REJ, r_pos, '0);
                nres   = 2'd1;
                ended  = 1'b1;
            end
        end else begin
            // try to extend the pending token
            unique case (r_mode)
                M_IDENT: begin
                    if (is_letter(c) || is_decimal(c) || c == C_UNDER) begin
                        n_tlen = sat_inc(r_tlen);
                        done   = 1'b1;
                    end else begin
                        res[0] = make_res(K_IDENT, r_tstart, r_tlen);
                        nres   = 2'd1;
                        n_mode = M_START;
                    end
                end
                M_ZERO, M_INT: begin
                    if (r_mode == M_INT && is_decimal(c)) begin
                        n_tlen = sat_inc(r_tlen);
                        done   = 1'b1;
                    end else if (c == C_DOT) begin
                        n_tlen = sat_inc(r_tlen);
                        n_mode = M_FRAC;
                        done   = 1'b1;
                    end else begin
                        res[0] = make_res(K_INT, r_tstart, r_tlen);
                        nres   = 2'd1;
                        n_mode = M_START;
                    end
                end
                M_FRAC: begin
                    if (is_decimal(c)) begin
                        n_tlen = sat_inc(r_tlen);
                        done   = 1'b1;
                    end else if (c == C_LO_F || c == C_UP_F) begin
                        res[0] = make_res(K_FLOAT, r_tstart, sat_inc(r_tlen));
                        nres   = 2'd1;
                        n_mode = M_START;
                        done   = 1'b1;
                    end else begin
                        res[0] = make_res(K_DOUBLE, r_tstart, r_tlen);
                        nres   = 2'd1;
                        n_mode = M_START;
                    end
                end
                default: begin
                    n_mode = M_START;
                end
            endcase

            // start a new token, emit a one-byte token or the end word, skip white space or reject
            if (!done) begin
                if (c == C_NUL) begin
                    res[nres[0]] = make_res(K_END_OK, r_pos, '0);
                    nres         = nres + 2'd1;
                    ended        = 1'b1;
                end else if (is_white(c)) begin
                    n_mode = M_START;
                end else if (is_letter(c) || c == C_UNDER) begin
                    n_mode   = M_IDENT;
                    n_tstart = r_pos;
                    n_tlen   = t_pos'(1);
                end else if (c == C_ZERO) begin
                    n_mode   = M_ZERO;
                    n_tstart = r_pos;
                    n_tlen   = t_pos'(1);
                end else if (is_decimal(c)) begin
                    n_mode   = M_INT;
                    n_tstart = r_pos;
                    n_tlen   = t_pos'(1);
                end else if (c == C_LPAREN) begin
                    res[nres[0]] = make_res(K_LPAREN, r_pos, t_pos'(1));
                    nres         = nres + 2'd1;
                end else if (c == C_RPAREN) begin
                    res[nres[0]] = make_res(K_RPAREN, r_pos, t_pos'(1));
                    nres         = nres + 2'd1;
                end else if (c == C_LBRACE) begin
                    res[nres[0]] = make_res(K_LBRACE, r_pos, t_pos'(1));
                    nres         = nres + 2'd1;
                end else if (c == C_RBRACE) begin
                    res[nres[0]] = make_res(K_RBRACE, r_pos, t_pos'(1));
                    nres         = nres + 2'd1;
                end else if (is_op(c)) begin
                    res[nres[0]] = make_res(K_OP, r_pos, t_pos'(1));
                    nres         = nres + 2'd1;
                end else if (c == C_SEMI) begin
                    res[nres[0]] = make_res(K_SEMI, r_pos, t_pos'(1));
                    nres         = nres + 2'd1;
                end else begin
                    n_mode = M_REJECT;
                end
            end
        end

        // end of text returns to the reset state
        if (ended) begin
            n_mode   = M_START;
            n_pos    = '0;
            n_tstart = '0;
            n_tlen   = '0;
        end

        // flag the final word of this byte
        if (nres == 2'd1) begin
            res[0].last = 1'b1;
        end else if (nres == 2'd2) begin
            res[1].last = 1'b1;
        end
    end

    // scanner state and result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_START;
            r_pos    <= '0;
            r_tstart <= '0;
            r_tlen   <= '0;
            r_wr     <= '0;
            r_rd     <= '0;
            r_cnt    <= '0;
        end else begin
            if (acc) begin
                r_mode   <= n_mode;
                r_pos    <= n_pos;
                r_tstart <= n_tstart;
                r_tlen   <= n_tlen;
                r_wr     <= r_wr + QAW'(nres);
            end
            if (pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            r_cnt <= r_cnt + (acc ? (QAW+1)'(nres) : '0) - (pop ? (QAW+1)'(1) : '0);
        end
        if (acc && nres != 2'd0) begin
            r_q[r_wr] <= res[0];
        end
        if (acc && nres == 2'd2) begin
            r_q[r_wr + QAW'(1)] <= res[1];
        end
    end

endmodule

>>> tb/sv/c_token_lexer_unit_tb.sv
module c_token_lexer_unit_tb;
    import ctl_pkg::*;

    // scanner modes of the predictor
    typedef enum logic [2:0] {
        SCAN_START,
        SCAN_IDENT,
        SCAN_ZERO,
        SCAN_INT,
        SCAN_FRAC,
        SCAN_REJECT
    } t_scan;

    // tracks the lexer state from the accepted bytes and holds the token words still due
    class lexer_tracker;
        t_scan       scan;
        logic [15:0] text_pos;
        logic [15:0] tok_start;
        logic [15:0] tok_len;
        t_result     tokens_due[$];
        int          errors;
        int          live_bytes;

        function new();
            restart();
            errors     = 0;
            live_bytes = 0;
        endfunction

        function void restart();
            scan      = SCAN_START;
            text_pos  = '0;
            tok_start = '0;
            tok_len   = '0;
        endfunction

        function logic [15:0] bump(logic [15:0] v);
            return (v == 16'hFFFF) ? v : v + 16'd1;
        endfunction

        function bit is_latin(logic [7:0] c);
            return (c >= C_LO_A && c <= C_LO_Z) || (c >= C_UP_A && c <= C_UP_Z);
        endfunction

        function bit is_num(logic [7:0] c);
            return c >= C_ZERO && c <= C_NINE;
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == C_SPACE || (c >= C_TAB && c <= C_CR);
        endfunction

        function void due(t_kind k, logic [15:0] s, logic [15:0] l);
            t_result r;
            r.kind      = k;
            r.start_pos = s;
            r.tok_len   = l;
            r.last      = 1'b0;
            tokens_due.insert(tokens_due.size(), r);
        endfunction

        function void mark_last();
            tokens_due[tokens_due.size() - 1].last = 1'b1;
        endfunction

        function int pending();
            return tokens_due.size();
        endfunction

        // advance the scanner by one accepted byte
        function void take_byte(logic [7:0] c);
            logic [15:0] at;
            int          n_before;
            bit          grown;
            at       = text_pos;
            n_before = tokens_due.size();
            grown    = 1'b0;
            live_bytes++;

            // rejected text: only the end marker matters
            if (scan == SCAN_REJECT) begin
                if (c == C_NUL) begin
                    due(K_END_REJ, at, 16'd0);
                    mark_last();
                    restart();
                end else begin
                    text_pos = bump(text_pos);
                end
                return;
            end

            // try to grow the pending token
            case (scan)
                SCAN_IDENT: begin
                    if (is_latin(c) || is_num(c) || c == C_UNDER) begin
                        tok_len = bump(tok_len);
                        grown   = 1'b1;
                    end else begin
                        due(K_IDENT, tok_start, tok_len);
                        scan = SCAN_START;
                    end
                end
                SCAN_ZERO, SCAN_INT: begin
                    if (scan == SCAN_INT && is_num(c)) begin
                        tok_len = bump(tok_len);
                        grown   = 1'b1;
                    end else if (c == C_DOT) begin
                        tok_len = bump(tok_len);
                        scan    = SCAN_FRAC;
                        grown   = 1'b1;
                    end else begin
                        due(K_INT, tok_start, tok_len);
                        scan = SCAN_START;
                    end
                end
                SCAN_FRAC: begin
                    if (is_num(c)) begin
                        tok_len = bump(tok_len);
                        grown   = 1'b1;
                    end else if (c == C_LO_F || c == C_UP_F) begin
                        due(K_FLOAT, tok_start, bump(tok_len));
                        scan  = SCAN_START;
                        grown = 1'b1;
                    end else begin
                        due(K_DOUBLE, tok_start, tok_len);
                        scan = SCAN_START;
                    end
                end
                default: begin
                    scan = SCAN_START;
                end
            endcase

            // classify a byte that starts something new
            if (!grown) begin
                if (c == C_NUL) begin
                    due(K_END_OK, at, 16'd0);
                    mark_last();
                    restart();
                    return;
                end else if (is_blank(c)) begin
                    // skipped
                end else if (is_latin(c) || c == C_UNDER) begin
                    scan      = SCAN_IDENT;
                    tok_start = at;
                    tok_len   = 16'd1;
                end else if (c == C_ZERO) begin
                    scan      = SCAN_ZERO;
                    tok_start = at;
                    tok_len   = 16'd1;
                end else if (is_num(c)) begin
                    scan      = SCAN_INT;
                    tok_start = at;
                    tok_len   = 16'd1;
                end else if (c == C_LPAREN) begin
                    due(K_LPAREN, at, 16'd1);
                end else if (c == C_RPAREN) begin
                    due(K_RPAREN, at, 16'd1);
                end else if (c == C_LBRACE) begin
                    due(K_LBRACE, at, 16'd1);
                end else if (c == C_RBRACE) begin
                    due(K_RBRACE, at, 16'd1);
                end else if (c == C_PLUS || c == C_MINUS || c == C_SLASH || c == C_STAR ||
                             c == C_EQUAL) begin
                    due(K_OP, at, 16'd1);
                end else if (c == C_SEMI) begin
                    due(K_SEMI, at, 16'd1);
                end else begin
                    scan = SCAN_REJECT;
                end
            end

            text_pos = bump(text_pos);
            if (tokens_due.size() > n_before)
                mark_last();
        endfunction

        function void report(string field, int unsigned want, int unsigned got);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
        endfunction

        // compare one token word with the oldest one due
        function void match_token(t_result got);
            t_result want;
            if (tokens_due.size() == 0) begin
                $display({"%0t: unexpected word, expected none, ",
                          "actual kind=%0d start=%0d len=%0d last=%0b"},
                         $time, got.kind, got.start_pos, got.tok_len, got.last);
                errors++;
                return;
            end
            want = tokens_due.pop_front();
            if (got.kind !== want.kind)
                report("kind", want.kind, got.kind);
            if (got.start_pos !== want.start_pos)
                report("start_pos", want.start_pos, got.start_pos);
            if (got.tok_len !== want.tok_len)
                report("tok_len", want.tok_len, got.tok_len);
            if (got.last !== want.last)
                report("last", want.last, got.last);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    ctl_byte_if byte_if();
    ctl_tok_if  tok_if();

    c_token_lexer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_if),
        .o_out   (tok_if)
    );

    lexer_tracker tracker = new();

    logic [7:0] text_q[$];
    bit         src_calm  = 1'b0;
    bit         sink_calm = 1'b0;
    int         stall_left = 0;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run time limit
    initial begin
        #40_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // mostly short pauses, now and then a long one
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // both handshakes, seen before this edge's updates
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (byte_if.valid && byte_if.ready)
                tracker.take_byte(byte_if.ch);
            if (tok_if.valid && tok_if.ready) begin
                got.kind      = tok_if.kind;
                got.start_pos = tok_if.start_pos;
                got.tok_len   = tok_if.tok_len;
                got.last      = tok_if.last;
                tracker.match_token(got);
            end
        end
    end

    // token sink with random stalls
    initial begin
        tok_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                tok_if.ready <= 1'b0;
                stall_left--;
            end else begin
                tok_if.ready <= 1'b1;
                if (!sink_calm && $urandom_range(0, 3) == 0)
                    stall_left = pause_len();
            end
        end
    end

    // offer one byte and wait until it is taken
    task automatic send_byte(input logic [7:0] c);
        int gap;
        gap = src_calm ? 0 : pause_len();
        if (gap > 0) begin
            byte_if.valid <= 1'b0;
            byte_if.ch    <= 8'($urandom_range(0, 255));
            repeat (gap) @(posedge i_clk);
        end
        byte_if.valid <= 1'b1;
        byte_if.ch    <= c;
        @(posedge i_clk);
        while (!byte_if.ready)
            @(posedge i_clk);
    endtask

    task automatic send_text();
        foreach (text_q[i])
            send_byte(text_q[i]);
        text_q.delete();
    endtask

    // hold the source until every due word is out
    task automatic wait_drained();
        int guard;
        guard = 0;
        byte_if.valid <= 1'b0;
        do begin
            @(posedge i_clk);
            guard++;
        end while (tracker.pending() != 0 && guard < 200000);
        if (tracker.pending() != 0) begin
            $display("%0t: %0d expected words never arrived", $time, tracker.pending());
            tracker.errors++;
        end
    endtask

    function automatic void add_byte(input logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endfunction

    function automatic void add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    function automatic logic [7:0] pick_letter();
        int r;
        r = $urandom_range(0, 25);
        return $urandom_range(0, 1) ? 8'(C_LO_A + r) : 8'(C_UP_A + r);
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'(C_ZERO + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_blank();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? C_SPACE : 8'(C_TAB + r);
    endfunction

    // integer part; a leading zero now and then splits into two ints
    function automatic void add_number();
        if ($urandom_range(0, 3) == 0)
            add_byte(C_ZERO);
        else
            add_byte(8'(C_ZERO + $urandom_range(1, 9)));
        repeat ($urandom_range(0, 4)) add_byte(pick_digit());
    endfunction

    // one well-formed token or a run of blanks, maybe a separator, rarely noise
    function automatic void add_token();
        int r;
        case ($urandom_range(0, 8))
            0, 1: begin
                add_byte(($urandom_range(0, 4) == 0) ? C_UNDER : pick_letter());
                repeat ($urandom_range(0, 7)) begin
                    r = $urandom_range(0, 3);
                    add_byte(r == 0 ? C_UNDER : (r == 1 ? pick_digit() : pick_letter()));
                end
            end
            2: add_number();
            3, 4: begin
                add_number();
                add_byte(C_DOT);
                repeat ($urandom_range(0, 3)) add_byte(pick_digit());
                if ($urandom_range(0, 1))
                    add_byte($urandom_range(0, 1) ? C_LO_F : C_UP_F);
            end
            5: begin
                case ($urandom_range(0, 3))
                    0: add_byte(C_LPAREN);
                    1: add_byte(C_RPAREN);
                    2: add_byte(C_LBRACE);
                    default: add_byte(C_RBRACE);
                endcase
            end
            6: begin
                case ($urandom_range(0, 4))
                    0: add_byte(C_PLUS);
                    1: add_byte(C_MINUS);
                    2: add_byte(C_SLASH);
                    3: add_byte(C_STAR);
                    default: add_byte(C_EQUAL);
                endcase
            end
            7: add_byte(C_SEMI);
            default: repeat ($urandom_range(1, 3)) add_byte(pick_blank());
        endcase
        if ($urandom_range(0, 1))
            add_byte(pick_blank());
        if ($urandom_range(0, 39) == 0)
            add_byte(8'($urandom_range(1, 255)));
    endfunction

    // stimulus
    initial begin
        int n_text;
        i_rst_n       <= 1'b0;
        byte_if.valid <= 1'b0;
        byte_if.ch    <= 8'h00;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty text, every one-byte token, numbers, rejections
        add_byte(C_NUL);
        add_str("_Zz9(){}+-*/=;");
        add_byte(C_NUL);
        // leading zero, floats with and without fraction, trailing double
        add_str("05 1.2f3.F9.");
        add_byte(C_NUL);
        // high byte after a pending ident
        add_str("x");
        add_byte(8'hFF);
        add_str("y;");
        add_byte(C_NUL);
        // dot between tokens, then a control byte
        add_str(" .");
        add_byte(C_NUL);
        add_byte(8'h01);
        add_byte(C_NUL);
        send_text();
        wait_drained();

        // random texts
        n_text = 0;
        while (tracker.live_bytes < 1900) begin
            src_calm  = ($urandom_range(0, 7) == 0);
            sink_calm = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 14) == 0) begin
                repeat ($urandom_range(3, 10)) add_byte(8'($urandom_range(1, 255)));
            end else begin
                repeat ($urandom_range(1, 12)) add_token();
            end
            add_byte(C_NUL);
            send_text();
            n_text++;
            if (n_text % 50 == 49)
                wait_drained();
        end

        src_calm  = 1'b0;
        sink_calm = 1'b0;
        add_str("a1 ");
        add_byte(C_NUL);
        send_text();

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (tracker.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
